### design/ecft_pkg.sv
package ecft_pkg;

	localparam int DEPTH_DEF = 4;
	localparam int FACT_W    = 24;
	localparam int CNT_W     = 24;
	localparam int PROD_W    = FACT_W + CNT_W;
	localparam int DIV_STEPS = PROD_W;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	localparam logic [FACT_W-1:0] FIX_ONE    = 24'd65536;
	localparam logic [FACT_W-1:0] FIX_085    = 24'd55706;
	localparam logic [FACT_W-1:0] FIX_075    = 24'd49152;
	localparam logic [FACT_W-1:0] FACTOR_MAX = 24'hFFFFFF;

	localparam logic [1:0] COMP_Y = 2'd0;
	localparam logic [1:0] COMP_U = 2'd1;
	localparam logic [1:0] COMP_V = 2'd2;

	localparam logic [1:0] SORT_INTRA = 2'd0;
	localparam logic [1:0] SORT_L1    = 2'd1;
	localparam logic [1:0] SORT_L2    = 2'd2;

	// value of an entry that was never written, by band (from 0) and sort
	function automatic logic [FACT_W-1:0] init_factor(
		input logic [3:0] b0,
		input logic [1:0] srow,
		input logic [4:0] bands
	);
		logic [4:0] bx;
		logic       intra;
		bx    = {1'b0, b0};
		intra = (srow == SORT_INTRA);
		if (bx == bands - 5'd1) begin
			return intra ? FIX_ONE : FIX_085;
		end else if (bx + 5'd4 >= bands) begin
			return intra ? FIX_085 : FIX_075;
		end else begin
			return FIX_075;
		end
	endfunction

endpackage

### design/entropy_correction_factor_table_top.sv
// Correction factor table: one 24-bit factor (16 fraction bits) per component, frame sort
// and subband, held in a single-port-read, single-port-write memory. Each input word with a
// band in range reads one entry and, when both bit counts are nonzero, replaces it by
// factor*actual/estimated, saturated, returning the new value; otherwise it returns the
// stored value unchanged. An out-of-range band returns a zero factor with band_error set.
// One word is processed at a time; an update runs through the 48-step bit-serial divider.
// The output register lets a new word be accepted while the previous result is still
// stalled. No clearing pass is needed after reset: per-entry written flags make untouched
// entries read as their initial values.
module entropy_correction_factor_table_top import ecft_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [3:0]        band,
	input  logic [1:0]        frame_sort,
	input  logic [1:0]        component,
	input  logic [CNT_W-1:0]  estimated_bits,
	input  logic [CNT_W-1:0]  produced_bits,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [FACT_W-1:0] factor,
	output logic              band_error
);

	localparam int BANDS   = 3 * DEPTH + 1;
	localparam int ENTRIES = 9 * BANDS;
	localparam int AW      = $clog2(ENTRIES);
	localparam logic [4:0]    BANDS5  = 5'(BANDS);
	localparam logic [AW-1:0] BANDS_A = AW'(BANDS);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t            state_q;
	logic              in_acc;
	logic              band_ok;
	logic [1:0]        crow;
	logic [1:0]        srow;
	logic [AW-1:0]     row_a;
	logic [AW-1:0]     idx_d;
	logic [AW-1:0]     idx_q;
	logic [3:0]        b0_q;
	logic [1:0]        srow_q;
	logic [CNT_W-1:0]  est_q;
	logic [CNT_W-1:0]  act_q;
	logic [FACT_W-1:0] res_q;
	logic              err_q;
	logic [FACT_W-1:0] mem_rdata;
	logic              mem_rvalid;
	logic              mem_we;
	logic [FACT_W-1:0] f_cur;
	logic [PROD_W-1:0] prod_d;
	logic [PROD_W-1:0] prod_q;
	logic              div_start;
	logic              div_done;
	logic [PROD_W-1:0] quo;
	logic [FACT_W-1:0] quo_sat;
	logic              out_free;
	logic              out_valid_q;
	logic [FACT_W-1:0] factor_q;
	logic              band_error_q;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign band_ok  = (band != 4'd0) && ({1'b0, band} <= BANDS5);

	always_comb begin
		case (component)
			COMP_U:  crow = 2'd1;
			COMP_V:  crow = 2'd2;
			default: crow = 2'd0;
		endcase
		case (frame_sort)
			SORT_INTRA: srow = SORT_INTRA;
			SORT_L1:    srow = SORT_L1;
			default:    srow = SORT_L2;
		endcase
	end

	assign row_a = AW'(crow) * AW'(3) + AW'(srow);
	assign idx_d = row_a * BANDS_A + AW'(band) - AW'(1);

	ecft_mem #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (in_acc && band_ok),
		.raddr  (idx_d),
		.we     (mem_we),
		.waddr  (idx_q),
		.wdata  (quo_sat),
		.rdata  (mem_rdata),
		.rvalid (mem_rvalid)
	);

	assign f_cur  = mem_rvalid ? mem_rdata : init_factor(b0_q, srow_q, BANDS5);
	assign prod_d = PROD_W'(f_cur) * PROD_W'(act_q);

	assign div_start = (state_q == ST_MUL);

	ecft_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (est_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign quo_sat  = (|quo[PROD_W-1:FACT_W]) ? FACTOR_MAX : quo[FACT_W-1:0];
	assign mem_we   = (state_q == ST_DIV) && div_done;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q  <= idx_d;
			b0_q   <= band - 4'd1;
			srow_q <= srow;
			est_q  <= estimated_bits;
			act_q  <= produced_bits;
			res_q  <= '0;
			err_q  <= !band_ok;
		end
		if (state_q == ST_READ) begin
			prod_q <= prod_d;
			res_q  <= f_cur;
		end
		if (mem_we) begin
			res_q <= quo_sat;
		end
		if ((state_q == ST_DONE) && out_free) begin
			factor_q     <= res_q;
			band_error_q <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= band_ok ? ST_READ : ST_DONE;
					end
				end
				ST_READ: begin
					if ((est_q == '0) || (act_q == '0)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign factor     = factor_q;
	assign band_error = band_error_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && band_error |-> factor == '0)
		else $error("band error word carries a nonzero factor");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("second word taken while one is in flight");

endmodule

### design/ecft_mem.sv
module ecft_mem import ecft_pkg::*; #(
	parameter int ENTRIES = 9 * (3 * DEPTH_DEF + 1),
	parameter int AW      = $clog2(9 * (3 * DEPTH_DEF + 1))
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [FACT_W-1:0] wdata,
	output logic [FACT_W-1:0] rdata,
	output logic              rvalid
);

	logic [FACT_W-1:0] mem [ENTRIES];
	logic [ENTRIES-1:0] vld_q;
	logic [FACT_W-1:0] rdata_q;
	logic              rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// written flags; an unwritten entry reads as its reset value upstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= vld_q[raddr];
			end
		end
	end

	assign rdata  = rdata_q;
	assign rvalid = rvalid_q;

endmodule

### design/ecft_div.sv
module ecft_div import ecft_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic              done,
	output logic [PROD_W-1:0] quotient
);

	logic [PROD_W-1:0] dq_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    rem_sh;
	logic [CNT_W:0]    rem_nx;
	logic              ge;

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q, dq_q[PROD_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[PROD_W-2:0], ge};
			rem_q <= rem_nx[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule
